/* sv/mck_pkg.sv */
// Shared types, constants and the Morse pattern table for the character keyer.
package mck_pkg;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_Z = 8'h7a;
  localparam logic [7:0] CASE_OFS = 8'h20;

  localparam logic [2:0] UNITS_ELEM_GAP = 3'd1;
  localparam logic [2:0] UNITS_DIT      = 3'd1;
  localparam logic [2:0] UNITS_DAH      = 3'd3;
  localparam logic [2:0] UNITS_CHAR_GAP = 3'd3;
  localparam logic [2:0] UNITS_WORD_GAP = 3'd4;

  localparam int unsigned MAX_ELEMS = 7;

  // pat holds the elements first-to-last from the MSB down, 1 = dah
  typedef struct packed {
    logic       hit;
    logic       space;
    logic [2:0] len;
    logic [6:0] pat;
  } lookup_t;

  function automatic lookup_t mk(input logic [2:0] n, input logic [6:0] b);
    lookup_t r;
    r.hit   = 1'b1;
    r.space = 1'b0;
    r.len   = n;
    r.pat   = b << (3'd7 - n);
    return r;
  endfunction

  function automatic lookup_t morse_lookup(input logic [7:0] code);
    logic [7:0] c;
    lookup_t    r;
    c = code;
    if (c >= CH_LOW_A && c <= CH_LOW_Z) begin
      c = c - CASE_OFS;
    end
    r = '0;
    case (c)
      "A": r = mk(3'd2, 7'b01);
      "B": r = mk(3'd4, 7'b1000);
      "C": r = mk(3'd4, 7'b1010);
      "D": r = mk(3'd3, 7'b100);
      "E": r = mk(3'd1, 7'b0);
      "F": r = mk(3'd4, 7'b0010);
      "G": r = mk(3'd3, 7'b110);
      "H": r = mk(3'd4, 7'b0000);
      "I": r = mk(3'd2, 7'b00);
      "J": r = mk(3'd4, 7'b0111);
      "K": r = mk(3'd3, 7'b101);
      "L": r = mk(3'd4, 7'b0100);
      "M": r = mk(3'd2, 7'b11);
      "N": r = mk(3'd2, 7'b10);
      "O": r = mk(3'd3, 7'b111);
      "P": r = mk(3'd4, 7'b0110);
      "Q": r = mk(3'd4, 7'b1101);
      "R": r = mk(3'd3, 7'b010);
      "S": r = mk(3'd3, 7'b000);
      "T": r = mk(3'd1, 7'b1);
      "U": r = mk(3'd3, 7'b001);
      "V": r = mk(3'd4, 7'b0001);
      "W": r = mk(3'd3, 7'b011);
      "X": r = mk(3'd4, 7'b1001);
      "Y": r = mk(3'd4, 7'b1011);
      "Z": r = mk(3'd4, 7'b1100);
      "0": r = mk(3'd5, 7'b11111);
      "1": r = mk(3'd5, 7'b01111);
      "2": r = mk(3'd5, 7'b00111);
      "3": r = mk(3'd5, 7'b00011);
      "4": r = mk(3'd5, 7'b00001);
      "5": r = mk(3'd5, 7'b00000);
      "6": r = mk(3'd5, 7'b10000);
      "7": r = mk(3'd5, 7'b11000);
      "8": r = mk(3'd5, 7'b11100);
      "9": r = mk(3'd5, 7'b11110);
      ".": r = mk(3'd6, 7'b010101);
      ",": r = mk(3'd6, 7'b110011);
      "?": r = mk(3'd6, 7'b001100);
      "'": r = mk(3'd6, 7'b011110);
      "!": r = mk(3'd6, 7'b101011);
      "/": r = mk(3'd5, 7'b10010);
      "(": r = mk(3'd5, 7'b10110);
      ")": r = mk(3'd6, 7'b101101);
      "&": r = mk(3'd5, 7'b01000);
      ":": r = mk(3'd6, 7'b111000);
      ";": r = mk(3'd6, 7'b101010);
      "=": r = mk(3'd5, 7'b10001);
      "+": r = mk(3'd5, 7'b01010);
      "-": r = mk(3'd6, 7'b100001);
      "_": r = mk(3'd6, 7'b001101);
      "\"": r = mk(3'd6, 7'b010010);
      "$": r = mk(3'd7, 7'b0001001);
      "@": r = mk(3'd6, 7'b011010);
      "<": r = mk(3'd5, 7'b10001);
      ">": r = mk(3'd6, 7'b000101);
      default: r = '0;
    endcase
    r.space = (c == CH_SPACE);
    return r;
  endfunction

endpackage

/* sv/mck_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module mck_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic                                       rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* sv/mck_lookup.sv */
// Character fold and Morse pattern lookup, registered on request accept.
module mck_lookup import mck_pkg::*; (
  input  logic       clk,
  input  logic       en,
  input  logic [7:0] char_code,
  output lookup_t    lk
);

  lookup_t lk_r;

  always_ff @(posedge clk) begin
    if (en) begin
      lk_r <= morse_lookup(char_code);
    end
  end

  assign lk = lk_r;

endmodule

/* sv/morse_character_keyer_core.sv */
// An accepted request goes to load, then emit registers its events on the output.
// Throughput: one event per cycle while the output is not stalled; a character
// takes a read of the state RAM, event sequencing and write-back before the next.
// Unknown characters, and a space before any character, skip emit and send nothing.
// Reset (rst_n, synchronous): time and first-character flag read as zero, dit_ticks = 1.
// The state RAM itself is not cleared; a valid flop masks it until the first write-back.
module morse_character_keyer_core import mck_pkg::*; #(
  parameter int TIME_BITS = 40
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_code,
  input  logic        in_start_text,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_key_down,
  output logic [2:0]  out_duration_units,
  output logic [17:0] out_duration_ticks,
  output logic [39:0] out_start_tick,
  output logic        out_last
);

  localparam int ST_W = TIME_BITS + 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_LOAD  = 2'd1;
  localparam logic [1:0] S_EMIT  = 2'd2;
  localparam logic [1:0] S_WRITE = 2'd3;

  logic [1:0]           state_r, state_nxt;
  logic [15:0]          dit_r;
  logic                 start_r;
  logic                 st_valid_r, st_valid_nxt;
  logic [TIME_BITS-1:0] time_r, time_nxt;
  logic                 seen_r, seen_nxt;
  logic                 space_r, space_nxt;
  logic                 pre_r, pre_nxt;
  logic                 gap_r, gap_nxt;
  logic [2:0]           k_r, k_nxt;

  logic                 ov_r, ov_nxt;
  logic                 okey_r, okey_nxt;
  logic [2:0]           ounits_r, ounits_nxt;
  logic [17:0]          oticks_r, oticks_nxt;
  logic [39:0]          ostart_r, ostart_nxt;
  logic                 olast_r, olast_nxt;

  lookup_t              lk;
  logic                 accept;
  logic                 ram_we;
  logic [ST_W-1:0]      ram_rd;
  logic                 rd_seen;
  logic [TIME_BITS-1:0] rd_time;

  logic                 ev_key;
  logic [2:0]           ev_units;
  logic                 ev_last;
  logic [17:0]          ev_ticks;
  logic [63:0]          time_64;
  logic                 slot_free;

  assign accept = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign ram_we = (state_r == S_WRITE);
  assign rd_seen = ram_rd[ST_W-1];
  assign rd_time = ram_rd[TIME_BITS-1:0];

  mck_ram #(
    .WIDTH(ST_W),
    .DEPTH(1)
  ) u_state_ram (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(1'b0),
    .wr_data({seen_r, time_r}),
    .rd_en  (accept),
    .rd_addr(1'b0),
    .rd_data(ram_rd)
  );

  mck_lookup u_lookup (
    .clk      (clk),
    .en       (accept),
    .char_code(in_char_code),
    .lk       (lk)
  );

  // current event from the sequencing flags
  always_comb begin
    ev_key   = 1'b0;
    ev_units = UNITS_ELEM_GAP;
    ev_last  = 1'b0;
    if (space_r) begin
      ev_units = UNITS_WORD_GAP;
      ev_last  = 1'b1;
    end else if (pre_r) begin
      ev_units = UNITS_CHAR_GAP;
    end else if (gap_r) begin
      ev_units = UNITS_ELEM_GAP;
    end else begin
      ev_key   = 1'b1;
      ev_units = lk.pat[3'd6 - k_r] ? UNITS_DAH : UNITS_DIT;
      ev_last  = (k_r == lk.len - 3'd1);
    end
  end

  assign ev_ticks  = 18'({15'd0, ev_units} * {2'd0, dit_r});
  assign time_64   = 64'(time_r);
  assign slot_free = !ov_r || out_ready;

  always_comb begin
    state_nxt    = state_r;
    st_valid_nxt = st_valid_r;
    time_nxt     = time_r;
    seen_nxt     = seen_r;
    space_nxt    = space_r;
    pre_nxt      = pre_r;
    gap_nxt      = gap_r;
    k_nxt        = k_r;
    ov_nxt       = ov_r && !out_ready;
    okey_nxt     = okey_r;
    ounits_nxt   = ounits_r;
    oticks_nxt   = oticks_r;
    ostart_nxt   = ostart_r;
    olast_nxt    = olast_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        if (start_r || !st_valid_r) begin
          seen_nxt = 1'b0;
          time_nxt = '0;
        end else begin
          seen_nxt = rd_seen;
          time_nxt = rd_time;
        end
        space_nxt = 1'b0;
        pre_nxt   = 1'b0;
        gap_nxt   = 1'b0;
        k_nxt     = 3'd0;
        state_nxt = S_WRITE;
        if (lk.space) begin
          if (seen_nxt) begin
            space_nxt = 1'b1;
            state_nxt = S_EMIT;
          end
        end else if (lk.hit) begin
          pre_nxt   = seen_nxt;
          seen_nxt  = 1'b1;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          ov_nxt     = 1'b1;
          okey_nxt   = ev_key;
          ounits_nxt = ev_units;
          oticks_nxt = ev_ticks;
          ostart_nxt = time_64[39:0];
          olast_nxt  = ev_last;
          time_nxt   = time_r + TIME_BITS'(ev_ticks);
          if (space_r) begin
            space_nxt = 1'b0;
          end else if (pre_r) begin
            pre_nxt = 1'b0;
          end else if (gap_r) begin
            gap_nxt = 1'b0;
          end else if (!ev_last) begin
            k_nxt   = k_r + 3'd1;
            gap_nxt = 1'b1;
          end
          if (ev_last) begin
            state_nxt = S_WRITE;
          end
        end
      end
      S_WRITE: begin
        st_valid_nxt = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      st_valid_r <= 1'b0;
      ov_r       <= 1'b0;
      dit_r      <= 16'd1;
    end else begin
      state_r    <= state_nxt;
      st_valid_r <= st_valid_nxt;
      ov_r       <= ov_nxt;
      if (cfg_wr_en) begin
        dit_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      start_r <= in_start_text;
    end
    time_r   <= time_nxt;
    seen_r   <= seen_nxt;
    space_r  <= space_nxt;
    pre_r    <= pre_nxt;
    gap_r    <= gap_nxt;
    k_r      <= k_nxt;
    okey_r   <= okey_nxt;
    ounits_r <= ounits_nxt;
    oticks_r <= oticks_nxt;
    ostart_r <= ostart_nxt;
    olast_r  <= olast_nxt;
  end

  assign out_valid          = ov_r;
  assign out_key_down       = okey_r;
  assign out_duration_units = ounits_r;
  assign out_duration_ticks = oticks_r;
  assign out_start_tick     = ostart_r;
  assign out_last           = olast_r;

endmodule
